// File: hw/rtl/ofi_pkg.sv
// ----------------------------------------------------------------------------
// ofi_pkg
// Shared types, constants and helper functions for the odometry frame
// integrator.
// ----------------------------------------------------------------------------
package ofi_pkg;

  localparam int PAYLOAD_BYTES_DEF = 32;
  localparam int STORE_DEPTH       = 32;
  localparam int STORE_AW          = 5;
  localparam int STORE_WORDS       = STORE_DEPTH / 4;
  localparam int WORD_AW           = 3;
  localparam int NUM_FLOATS        = 8;
  localparam int TRIG_TERMS        = 5;

  localparam logic [7:0]  HDR_BYTE       = 8'hA0;
  localparam logic [31:0] TICK_RESET     = 32'd4295;
  localparam logic [30:0] DEADBAND_RESET = 31'd26214;

  localparam logic signed [35:0] Q_PI         = 36'sd1686629713;
  localparam logic signed [35:0] Q_TWO_PI     = 36'sd3373259426;
  localparam logic signed [35:0] Q_HALF_PI    = 36'sd843314857;
  localparam logic signed [35:0] Q_QUARTER_PI = 36'sd421657428;
  localparam logic signed [31:0] DEG2RAD_Q32  = 32'sd74961329;
  localparam logic [31:0]        ONE_Q30      = 32'd1073741824;
  localparam logic [63:0]        POS_LIM      = 64'd4294967296;
  localparam logic [63:0]        HEAD_LIM     = 64'd2147483647;

  localparam logic [31:0] SDIV [TRIG_TERMS] = '{32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
  localparam logic [31:0] CDIV [TRIG_TERMS] = '{32'd90, 32'd56, 32'd30, 32'd12, 32'd2};
  localparam logic [31:0] SREC [TRIG_TERMS] = '{
    32'(64'd4294967296 / 110), 32'(64'd4294967296 / 72), 32'(64'd4294967296 / 42),
    32'(64'd4294967296 / 20), 32'(64'd4294967296 / 6)};
  localparam logic [31:0] CREC [TRIG_TERMS] = '{
    32'(64'd4294967296 / 90), 32'(64'd4294967296 / 56), 32'(64'd4294967296 / 30),
    32'(64'd4294967296 / 12), 32'(64'd4294967296 / 2)};

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } result_t;

  typedef enum logic {
    REG_TICK_SECONDS,
    REG_GYRO_DEADBAND
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR,
    PH_PAY
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_PREP, ST_SQR, ST_MA, ST_MB, ST_MC,
    ST_SIN, ST_ROT, ST_STX, ST_STY, ST_STH, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CONV, OP_PREP, OP_SQR, OP_MA, OP_MB, OP_MC,
    OP_SIN, OP_ROT, OP_STX, OP_STY, OP_STH, OP_FIN
  } op_t;

  typedef struct packed {
    logic                store_we;
    logic [STORE_AW-1:0] store_addr;
    logic [7:0]          store_data;
    logic                tick;
    logic                frame;
    op_t                 op;
    logic [2:0]          idx;
  } cmd_t;

  // IEEE single to Q16.16, truncated toward zero, saturated
  function automatic logic signed [31:0] f2q(logic [31:0] bits);
    logic [7:0]  e;
    logic [23:0] sig;
    logic [31:0] mag;
    logic        sat;
    e   = bits[30:23];
    sig = {1'b1, bits[22:0]};
    sat = 1'b0;
    mag = '0;
    if (e == 8'd0 || (e == 8'd255 && bits[22:0] != '0)) begin
      return '0;
    end
    if (e >= 8'd142) begin
      sat = 1'b1;
    end else if (e >= 8'd134) begin
      mag = 32'(sig) << (e - 8'd134);
    end else if ((8'd134 - e) < 8'd32) begin
      mag = 32'(sig) >> (8'd134 - e);
    end
    if (bits[31]) begin
      return (sat || mag[31]) ? 32'sh8000_0000 : -$signed(mag);
    end
    return (sat || mag[31]) ? 32'sh7FFF_FFFF : $signed(mag);
  endfunction

  // (mag * b) >> s limited to lim, sign applied; lo/hi are the partial products with the two 32-bit halves of b
  function automatic logic signed [33:0] mss(logic [63:0] lo, logic [63:0] hi,
                                             logic neg, int s, logic [63:0] lim);
    logic [63:0]        r;
    logic signed [33:0] m;
    if (hi > (lim >> (32 - s))) begin
      r = lim;
    end else begin
      r = (hi << (32 - s)) + (lo >> s);
      if (r > lim) begin
        r = lim;
      end
    end
    m = {1'b0, r[32:0]};
    return neg ? -m : m;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hw/rtl/ofi_ctrl.sv
// ----------------------------------------------------------------------------
// ofi_ctrl
// Frame parser and sequencer for the odometry frame integrator.
// ----------------------------------------------------------------------------
module ofi_ctrl #(
  parameter int PAYLOAD_BYTES = ofi_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  ofi_pkg::item_t item,
  output logic           item_stall,
  output logic           result_valid,
  input  logic           result_stall,
  output ofi_pkg::cmd_t  cmd
);
  import ofi_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

  state_t           state, state_next;
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [2:0]       idx, idx_next;
  logic             rv_next;
  logic [CNT_W-1:0] cnt_inc;
  logic             accept, is_byte, last_byte, fin_go;

  assign cnt_inc   = count + CNT_W'(1);
  assign accept    = item_valid && (state == ST_IDLE);
  assign is_byte   = accept && !item.command;
  assign last_byte = is_byte && (phase == PH_PAY) && (cnt_inc >= CNT_W'(PAYLOAD_BYTES));
  assign fin_go    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_HUNT;
      count        <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      count        <= count_next;
      idx          <= idx_next;
      result_valid <= rv_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    count_next = count;
    idx_next   = idx;
    rv_next    = result_valid && result_stall;
    case (state)
      ST_IDLE: begin
        if (is_byte) begin
          case (phase)
            PH_HUNT: phase_next = (item.rx_byte == HDR_BYTE) ? PH_HDR : PH_HUNT;
            PH_HDR: begin
              phase_next = (item.rx_byte == HDR_BYTE) ? PH_PAY : PH_HUNT;
              count_next = '0;
            end
            PH_PAY: begin
              if (last_byte) begin
                phase_next = PH_HUNT;
                count_next = '0;
                state_next = ST_CONV;
                idx_next   = '0;
              end else begin
                count_next = cnt_inc;
              end
            end
            default: phase_next = PH_HUNT;
          endcase
        end
      end
      ST_CONV: begin
        idx_next = idx + 3'd1;
        if (idx == 3'(NUM_FLOATS - 1)) begin
          state_next = ST_PREP;
          idx_next   = '0;
        end
      end
      ST_PREP: state_next = ST_SQR;
      ST_SQR:  state_next = ST_MA;
      ST_MA:   state_next = ST_MB;
      ST_MB:   state_next = ST_MC;
      ST_MC: begin
        if (idx == 3'(TRIG_TERMS - 1)) begin
          state_next = ST_SIN;
          idx_next   = '0;
        end else begin
          state_next = ST_MA;
          idx_next   = idx + 3'd1;
        end
      end
      ST_SIN: state_next = ST_ROT;
      ST_ROT: state_next = ST_STX;
      ST_STX: state_next = ST_STY;
      ST_STY: state_next = ST_STH;
      ST_STH: state_next = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
          rv_next    = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall     = (state != ST_IDLE);
    cmd.store_we   = is_byte && (phase == PH_PAY) && (count < CNT_W'(STORE_DEPTH));
    cmd.store_addr = count[STORE_AW-1:0];
    cmd.store_data = item.rx_byte;
    cmd.tick       = accept && item.command;
    cmd.frame      = last_byte;
    cmd.idx        = idx;
    case (state)
      ST_CONV: cmd.op = OP_CONV;
      ST_PREP: cmd.op = OP_PREP;
      ST_SQR:  cmd.op = OP_SQR;
      ST_MA:   cmd.op = OP_MA;
      ST_MB:   cmd.op = OP_MB;
      ST_MC:   cmd.op = OP_MC;
      ST_SIN:  cmd.op = OP_SIN;
      ST_ROT:  cmd.op = OP_ROT;
      ST_STX:  cmd.op = OP_STX;
      ST_STY:  cmd.op = OP_STY;
      ST_STH:  cmd.op = OP_STH;
      ST_FIN:  cmd.op = fin_go ? OP_FIN : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: hw/rtl/ofi_dp.sv
// ----------------------------------------------------------------------------
// ofi_dp
// Datapath: payload store, float conversion, sin/cos, pose integration.
// ----------------------------------------------------------------------------
module ofi_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  ofi_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  input  ofi_pkg::cmd_t     cmd,
  output ofi_pkg::result_t  result
);
  import ofi_pkg::*;

  logic [31:0]        tick_seconds;
  logic [30:0]        gyro_deadband;
  logic [31:0]        words [STORE_WORDS];
  logic [31:0]        elapsed;
  logic [63:0]        dt;
  logic signed [31:0] v [NUM_FLOATS];
  logic [1:0]         q;
  logic signed [31:0] x;
  logic [31:0]        x2, ts, tc, ps, pc, qs, qc;
  logic signed [31:0] sn;
  logic signed [33:0] vc, vs;
  logic [63:0]        plo [3];
  logic [63:0]        phi [3];
  logic               pneg [3];
  logic signed [63:0] gp [3];
  logic signed [31:0] pose_x, pose_y, heading;

  logic signed [35:0] hh, r;
  logic [1:0]         q_new;
  logic signed [63:0] xx, xts, pvc, pvs;
  logic [63:0]        x2ts, x2tc, psm, pcm;
  logic [31:0]        rem_s, rem_c, ts_new, tc_new;
  logic signed [31:0] c_sel, s_sel, g_src, g_db;
  logic signed [33:0] m_src;
  logic [32:0]        m_mag, g_abs;
  logic [63:0]        m_lo, m_hi;
  logic signed [63:0] g_prod;
  logic signed [33:0] dx, dy, dth;
  logic signed [35:0] h_sum, h_wrap;
  logic [WORD_AW-1:0] conv_w;
  logic [1:0]         gsel;

  always_comb begin
    hh = 36'(heading);
    if (hh > Q_QUARTER_PI + Q_HALF_PI) begin
      r = hh - (Q_HALF_PI <<< 1);  q_new = 2'd2;
    end else if (hh > Q_QUARTER_PI) begin
      r = hh - Q_HALF_PI;          q_new = 2'd1;
    end else if (hh < -(Q_QUARTER_PI + Q_HALF_PI)) begin
      r = hh + (Q_HALF_PI <<< 1);  q_new = 2'd2;
    end else if (hh < -Q_QUARTER_PI) begin
      r = hh + Q_HALF_PI;          q_new = 2'd3;
    end else begin
      r = hh;                      q_new = 2'd0;
    end

    xx   = x * x;
    x2ts = x2 * ts;
    x2tc = x2 * tc;
    psm  = ps * SREC[cmd.idx];
    pcm  = pc * CREC[cmd.idx];
    rem_s  = ps - 32'(qs * SDIV[cmd.idx]);
    rem_c  = pc - 32'(qc * CDIV[cmd.idx]);
    ts_new = ONE_Q30 - (qs + 32'(rem_s >= SDIV[cmd.idx]));
    tc_new = ONE_Q30 - (qc + 32'(rem_c >= CDIV[cmd.idx]));
    xts  = x * $signed(ts);

    case (q)
      2'd0:    begin c_sel = $signed(tc);  s_sel = sn;           end
      2'd1:    begin c_sel = -sn;          s_sel = $signed(tc);  end
      2'd2:    begin c_sel = -$signed(tc); s_sel = -sn;          end
      default: begin c_sel = sn;           s_sel = -$signed(tc); end
    endcase
    pvc = v[0] * c_sel;
    pvs = v[0] * s_sel;

    case (cmd.op)
      OP_STX:  begin m_src = vc;          g_src = v[5]; gsel = 2'd0; end
      OP_STY:  begin m_src = vs;          g_src = v[6]; gsel = 2'd1; end
      default: begin m_src = 34'(v[1]);   g_src = v[7]; gsel = 2'd2; end
    endcase
    m_mag  = m_src[33] ? 33'(-m_src) : m_src[32:0];
    m_lo   = 64'(m_mag) * {32'd0, dt[31:0]};
    m_hi   = 64'(m_mag) * {32'd0, dt[63:32]};
    g_abs  = g_src[31] ? 33'(-34'(g_src)) : {1'b0, g_src};
    g_db   = (g_abs <= 33'(gyro_deadband)) ? 32'sd0 : g_src;
    g_prod = g_db * DEG2RAD_Q32;

    dx    = mss(plo[0], phi[0], pneg[0], 32, POS_LIM);
    dy    = mss(plo[1], phi[1], pneg[1], 32, POS_LIM);
    dth   = mss(plo[2], phi[2], pneg[2], 19, HEAD_LIM);
    h_sum = hh + 36'(dth);
    if (h_sum > Q_PI) begin
      h_wrap = h_sum - Q_TWO_PI;
    end else if (h_sum < -Q_PI) begin
      h_wrap = h_sum + Q_TWO_PI;
    end else begin
      h_wrap = h_sum;
    end
    conv_w = cmd.idx[WORD_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_seconds  <= TICK_RESET;
      gyro_deadband <= DEADBAND_RESET;
      elapsed       <= '0;
      pose_x        <= '0;
      pose_y        <= '0;
      heading       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TICK_SECONDS:  tick_seconds  <= cfg_data;
          REG_GYRO_DEADBAND: gyro_deadband <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (cmd.tick && elapsed != '1) begin
        elapsed <= elapsed + 32'd1;
      end
      if (cmd.frame) begin
        elapsed <= '0;
      end
      if (cmd.op == OP_FIN) begin
        pose_x  <= sat32(36'(pose_x) + 36'(dx));
        pose_y  <= sat32(36'(pose_y) + 36'(dy));
        heading <= h_wrap[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      words[cmd.store_addr[STORE_AW-1:2]][8*cmd.store_addr[1:0] +: 8] <= cmd.store_data;
    end
    if (cmd.frame) begin
      dt <= elapsed * tick_seconds;
    end
    case (cmd.op)
      OP_CONV: v[conv_w] <= f2q(words[conv_w]);
      OP_PREP: begin
        q  <= q_new;
        x  <= 32'(r <<< 1);
        ts <= ONE_Q30;
        tc <= ONE_Q30;
      end
      OP_SQR: x2 <= xx[61:30];
      OP_MA: begin
        ps <= x2ts[61:30];
        pc <= x2tc[61:30];
      end
      OP_MB: begin
        qs <= psm[63:32];
        qc <= pcm[63:32];
      end
      OP_MC: begin
        ts <= ts_new;
        tc <= tc_new;
      end
      OP_SIN: sn <= xts[61:30];
      OP_ROT: begin
        vc <= pvc[63:30];
        vs <= pvs[63:30];
      end
      OP_STX, OP_STY, OP_STH: begin
        plo[gsel]  <= m_lo;
        phi[gsel]  <= m_hi;
        pneg[gsel] <= m_src[33];
        gp[gsel]   <= g_prod;
      end
      OP_FIN: begin
        result.pos_x        <= sat32(36'(pose_x) + 36'(dx));
        result.pos_y        <= sat32(36'(pose_y) + 36'(dy));
        result.heading      <= h_wrap[31:0];
        result.linear_speed <= v[0];
        result.turn_rate    <= v[1];
        result.gyro_x       <= 32'((gp[0] + 64'sd2147483648) >>> 32);
        result.gyro_y       <= 32'((gp[1] + 64'sd2147483648) >>> 32);
        result.gyro_z       <= 32'((64'sd4294967296 - gp[2]) >>> 33);
        result.accel_x      <= v[2];
        result.accel_y      <= (v[3] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v[3];
        result.accel_z      <= (v[4] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v[4];
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/odometry_frame_integrator.sv
// ----------------------------------------------------------------------------
// odometry_frame_integrator
// Serial frame parser with dead-reckoning pose integration.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall, item): each beat is either a serial
// byte (command 0) or one time tick (command 1). A frame is two 0xA0 header
// bytes followed by PAYLOAD_BYTES payload bytes; the first 32 carry eight
// little-endian floats.
// Bytes and ticks are taken one per cycle while the sequencer is idle. On
// the last payload byte the sequencer runs (8 float conversions, sin/cos
// with five series terms in steps MA, MB, MC on a sine and a cosine
// divide-by-constant unit shared by all terms, rotation and step products);
// item_stall is high during that time. The final step loads the result beat
// into the output register. While result_stall holds a beat, bytes keep
// being taken; a following frame waits in its last step until the register
// is free. Config port (cfg_valid/cfg_ready) is always ready: index 0 tick
// period, index 1 gyro deadband. Reset (synchronous) clears pose, tick count
// and parser, and restores the register defaults.
// ----------------------------------------------------------------------------
module odometry_frame_integrator #(
  parameter int PAYLOAD_BYTES = ofi_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ofi_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output ofi_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ofi_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]       cfg_data
);
  import ofi_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  ofi_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_stall  (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cmd         (cmd)
  );

  ofi_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .result   (result)
  );

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIN) |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  a_rv_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.op == OP_FIN))
    else $error("result beat without frame finish");

  a_head_rng: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.heading <= Q_PI && result.heading >= -Q_PI))
    else $error("heading outside wrap range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.frame |=> item_stall)
    else $error("input taken during frame processing");

endmodule
